[hdl/bhbm_pkg.sv]
// ----------------------------------------------------------------------------
// bhbm_pkg
// Shared types and constants for the bit history bucket merger.
// ----------------------------------------------------------------------------
`default_nettype none

package bhbm_pkg;

    // Fixed port widths
    localparam int IDX_W       = 6;
    localparam int OUT_COUNT_W = 32;
    localparam int USE_W       = 7;

    // Defaults for the top level parameters
    localparam int DEF_MAX_BUCKETS = 64;
    localparam int DEF_COUNT_WIDTH = 32;

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STREAM,
        ST_FLUSH,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic stream_step;
        logic flush;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic decode_stream;
        logic stream_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/bhbm_ctrl.sv]
// ----------------------------------------------------------------------------
// bhbm_ctrl
// Sequencer for the bucket merger: decode, merge stream, flush, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bhbm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output bhbm_pkg::ctrl_cmd_t       cmd,
    input  wire bhbm_pkg::dp_status_t status
);
    import bhbm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = status.decode_stream ? ST_STREAM : ST_RESULT;
            end
            ST_STREAM:
            begin
                cmd.stream_step = 1'b1;
                if (status.stream_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // hold until the output register can take the beat
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == ST_DECODE)
        else $error("accepted beat not followed by decode");

endmodule

`default_nettype wire

[hdl/bhbm_datapath.sv]
// ----------------------------------------------------------------------------
// bhbm_datapath
// Bucket store, merge stream registers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhbm_datapath #(
    parameter int MAX_BUCKETS = bhbm_pkg::DEF_MAX_BUCKETS,
    parameter int COUNT_WIDTH = bhbm_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bhbm_pkg::ctrl_cmd_t              cmd,
    output bhbm_pkg::dp_status_t                  status,
    input  wire logic                             command,
    input  wire logic                             bit_value,
    input  wire logic [bhbm_pkg::IDX_W-1:0]       bucket_index,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [bhbm_pkg::OUT_COUNT_W-1:0]      items_in_bucket,
    output logic [bhbm_pkg::OUT_COUNT_W-1:0]      ones_in_bucket,
    output logic [bhbm_pkg::OUT_COUNT_W-1:0]      zeroes_in_bucket,
    output logic [bhbm_pkg::USE_W-1:0]            buckets_in_use,
    output logic                                  index_valid,
    output logic                                  add_refused
);
    import bhbm_pkg::*;

    localparam int AW    = $clog2(MAX_BUCKETS);
    localparam int TW    = $clog2(MAX_BUCKETS + 1);
    localparam int CMP_W = (TW > IDX_W) ? TW : IDX_W;

    // Bucket store, newest at address 0
    logic [COUNT_WIDTH-1:0] items_mem [MAX_BUCKETS];
    logic [COUNT_WIDTH-1:0] ones_mem  [MAX_BUCKETS];

    logic                   cmd_reg;
    logic                   bit_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [TW-1:0]          total_reg;
    logic                   empty_reg;
    logic                   refused_reg;
    logic [TW-1:0]          rd_ptr_reg;
    logic [TW-1:0]          wr_ptr_reg;
    logic                   seen_reg;
    logic [COUNT_WIDTH-1:0] cur_items_reg;
    logic [COUNT_WIDTH-1:0] cur_ones_reg;
    logic [COUNT_WIDTH-1:0] q_items_reg;
    logic [COUNT_WIDTH-1:0] q_ones_reg;

    logic                   out_valid_reg;
    logic [OUT_COUNT_W-1:0] items_out_reg;
    logic [OUT_COUNT_W-1:0] ones_out_reg;
    logic [OUT_COUNT_W-1:0] zeroes_out_reg;
    logic [USE_W-1:0]       use_out_reg;
    logic                   index_valid_reg;
    logic                   refused_out_reg;

    logic                   is_read;
    logic                   read_hit;
    logic                   full;
    logic                   q_eq;
    logic                   merge_now;
    logic                   rd_more;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_witems;
    logic [COUNT_WIDTH-1:0] mem_wones;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [CMP_W-1:0]       idx_ext;
    logic [COUNT_WIDTH-1:0] sel_items;
    logic [COUNT_WIDTH-1:0] sel_ones;

    always_comb
    begin
        is_read   = (cmd_reg == CMD_READ);
        idx_ext   = CMP_W'(idx_reg);
        read_hit  = idx_ext < CMP_W'(total_reg);
        full      = total_reg >= TW'(MAX_BUCKETS);
        q_eq      = (cur_items_reg == q_items_reg);
        merge_now = q_eq && seen_reg;
        rd_more   = rd_ptr_reg < total_reg;

        status.decode_stream = !is_read && !empty_reg && !full;
        status.stream_last   = (rd_ptr_reg == total_reg);
        status.out_free      = !out_valid_reg || !out_stall;

        mem_we     = 1'b0;
        mem_waddr  = wr_ptr_reg[AW-1:0];
        mem_witems = cur_items_reg;
        mem_wones  = cur_ones_reg;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        if (cmd.decode)
        begin
            if (is_read)
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_ext[AW-1:0];
            end
            else if (empty_reg)
            begin
                // first add fills the empty bucket in place
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_witems = COUNT_WIDTH'(1);
                mem_wones  = COUNT_WIDTH'(bit_reg);
            end
            else if (!full)
            begin
                mem_re = 1'b1;
            end
        end

        if (cmd.stream_step)
        begin
            mem_we = !merge_now;
            if (rd_more)
            begin
                mem_re    = 1'b1;
                mem_raddr = rd_ptr_reg[AW-1:0];
            end
        end

        if (cmd.flush)
        begin
            mem_we = 1'b1;
        end

        sel_items = '0;
        sel_ones  = '0;
        if (is_read && read_hit && !empty_reg)
        begin
            sel_items = q_items_reg;
            sel_ones  = q_ones_reg;
        end
    end

    // Writes land below the read pointer, so the stream compacts in place
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            items_mem[mem_waddr] <= mem_witems;
            ones_mem[mem_waddr]  <= mem_wones;
        end
        if (mem_re)
        begin
            q_items_reg <= items_mem[mem_raddr];
            q_ones_reg  <= ones_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= TW'(1);
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decode && !is_read && empty_reg)
            begin
                empty_reg <= 1'b0;
            end
            if (cmd.flush)
            begin
                total_reg <= wr_ptr_reg + TW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg     <= command;
            bit_reg     <= bit_value;
            idx_reg     <= bucket_index;
            refused_reg <= 1'b0;
        end

        if (cmd.decode && !is_read && !empty_reg)
        begin
            if (full)
            begin
                refused_reg <= 1'b1;
            end
            else
            begin
                // new one-item bucket leads the stream
                cur_items_reg <= COUNT_WIDTH'(1);
                cur_ones_reg  <= COUNT_WIDTH'(bit_reg);
                seen_reg      <= 1'b0;
                wr_ptr_reg    <= '0;
                rd_ptr_reg    <= TW'(1);
            end
        end

        if (cmd.stream_step)
        begin
            if (merge_now)
            begin
                // third equal bucket: fold into the held one and drop it
                cur_items_reg <= cur_items_reg + q_items_reg;
                cur_ones_reg  <= cur_ones_reg + q_ones_reg;
                seen_reg      <= 1'b0;
            end
            else
            begin
                wr_ptr_reg    <= wr_ptr_reg + TW'(1);
                cur_items_reg <= q_items_reg;
                cur_ones_reg  <= q_ones_reg;
                seen_reg      <= q_eq;
            end
            if (rd_more)
            begin
                rd_ptr_reg <= rd_ptr_reg + TW'(1);
            end
        end

        if (cmd.load_out)
        begin
            items_out_reg   <= OUT_COUNT_W'(sel_items);
            ones_out_reg    <= OUT_COUNT_W'(sel_ones);
            zeroes_out_reg  <= OUT_COUNT_W'(sel_items - sel_ones);
            use_out_reg     <= USE_W'(total_reg);
            index_valid_reg <= is_read && read_hit;
            refused_out_reg <= refused_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign items_in_bucket  = items_out_reg;
    assign ones_in_bucket   = ones_out_reg;
    assign zeroes_in_bucket = zeroes_out_reg;
    assign buckets_in_use   = use_out_reg;
    assign index_valid      = index_valid_reg;
    assign add_refused      = refused_out_reg;

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg != '0 && total_reg <= TW'(MAX_BUCKETS))
        else $error("bucket count out of range");

    a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.stream_step |-> wr_ptr_reg < rd_ptr_reg)
        else $error("merge stream write overtook read");

    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> total_reg == TW'(1))
        else $error("empty store holds more than one bucket");

endmodule

`default_nettype wire

[hdl/bit_history_bucket_merger_unit.sv]
// ----------------------------------------------------------------------------
// bit_history_bucket_merger_unit
// Exponential histogram of a bit stream with in-place bucket merging.
// ----------------------------------------------------------------------------
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid, in_stall  | command, bit_value, bucket_index
//   out     | out_valid, out_stall| items/ones/zeroes_in_bucket, buckets_in_use,
//           |                     | index_valid, add_refused
//
// A read passes through accept, decode and output load; the beat shows in the
// cycle after the load. An add that pushes a bucket runs a merge stream and a
// flush between decode and load, as the merge stream reads and compacts the store one
// bucket per cycle. Other adds skip the stream. Reset leaves one empty bucket.
// One beat is worked at a time; a finished beat waits in the output register
// while the next is accepted, and a stalled result holds the one after it.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_history_bucket_merger_unit #(
    parameter int MAX_BUCKETS = bhbm_pkg::DEF_MAX_BUCKETS,
    parameter int COUNT_WIDTH = bhbm_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          command,
    input  wire logic                          bit_value,
    input  wire logic [bhbm_pkg::IDX_W-1:0]    bucket_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bhbm_pkg::OUT_COUNT_W-1:0]   items_in_bucket,
    output logic [bhbm_pkg::OUT_COUNT_W-1:0]   ones_in_bucket,
    output logic [bhbm_pkg::OUT_COUNT_W-1:0]   zeroes_in_bucket,
    output logic [bhbm_pkg::USE_W-1:0]         buckets_in_use,
    output logic                               index_valid,
    output logic                               add_refused
);
    import bhbm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bhbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    bhbm_datapath #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .command          (command),
        .bit_value        (bit_value),
        .bucket_index     (bucket_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .items_in_bucket  (items_in_bucket),
        .ones_in_bucket   (ones_in_bucket),
        .zeroes_in_bucket (zeroes_in_bucket),
        .buckets_in_use   (buckets_in_use),
        .index_valid      (index_valid),
        .add_refused      (add_refused)
    );

endmodule

`default_nettype wire

[tb/sv/bhbm_history_checker.sv]
// ----------------------------------------------------------------------------
// bhbm_history_checker
// Watches both channels of the bucket merger, keeps its own copy of the
// bucket history, and checks every result beat against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhbm_history_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             command,
    input  logic                             bit_value,
    input  logic [bhbm_pkg::IDX_W-1:0]       bucket_index,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [bhbm_pkg::OUT_COUNT_W-1:0] items_in_bucket,
    input  logic [bhbm_pkg::OUT_COUNT_W-1:0] ones_in_bucket,
    input  logic [bhbm_pkg::OUT_COUNT_W-1:0] zeroes_in_bucket,
    input  logic [bhbm_pkg::USE_W-1:0]       buckets_in_use,
    input  logic                             index_valid,
    input  logic                             add_refused,
    output int                               error_count,
    output int                               pending_results,
    output int                               checked_results
);
    import bhbm_pkg::*;

    localparam int HIST_DEPTH = DEF_MAX_BUCKETS;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] items;
        logic [OUT_COUNT_W-1:0] ones;
        logic [OUT_COUNT_W-1:0] zeroes;
        logic [USE_W-1:0]       used;
        logic                   valid;
        logic                   refused;
    } bucket_report_t;

    // Predicted history, newest bucket at position 0
    logic [DEF_COUNT_WIDTH-1:0] hist_items [HIST_DEPTH];
    logic [DEF_COUNT_WIDTH-1:0] hist_ones  [HIST_DEPTH];
    int                         held_buckets;

    bucket_report_t expected_reports[$];

    // Apply one input beat to the history and return the report it yields
    function automatic bucket_report_t predict_report(input logic cmd, input logic bitv,
                                                      input logic [IDX_W-1:0] idx);
        bucket_report_t rep;
        int  cur;
        int  k;
        bit  seen_pair;
        rep = '0;
        if (cmd == CMD_ADD)
        begin
            if (hist_items[0] == '0)
            begin
                hist_items[0] = hist_items[0] + DEF_COUNT_WIDTH'(1);
                hist_ones[0]  = hist_ones[0] + DEF_COUNT_WIDTH'(bitv);
            end
            else if (held_buckets >= HIST_DEPTH)
            begin
                rep.refused = 1'b1;
            end
            else
            begin
                for (k = held_buckets; k > 0; k--)
                begin
                    hist_items[k] = hist_items[k-1];
                    hist_ones[k]  = hist_ones[k-1];
                end
                hist_items[0] = DEF_COUNT_WIDTH'(1);
                hist_ones[0]  = DEF_COUNT_WIDTH'(bitv);
                held_buckets++;
                // Merge pass: on a third equal neighbor, fold the older two together
                cur = 0;
                seen_pair = 1'b0;
                while (cur + 1 < held_buckets)
                begin
                    if (hist_items[cur] == hist_items[cur+1])
                    begin
                        if (seen_pair)
                        begin
                            hist_items[cur] = hist_items[cur] + hist_items[cur+1];
                            hist_ones[cur]  = hist_ones[cur] + hist_ones[cur+1];
                            for (k = cur + 1; k + 1 < held_buckets; k++)
                            begin
                                hist_items[k] = hist_items[k+1];
                                hist_ones[k]  = hist_ones[k+1];
                            end
                            held_buckets--;
                            seen_pair = 1'b0;
                        end
                        else
                        begin
                            seen_pair = 1'b1;
                            cur++;
                        end
                    end
                    else
                    begin
                        seen_pair = 1'b0;
                        cur++;
                    end
                end
            end
        end
        else if (int'(idx) < held_buckets)
        begin
            rep.valid  = 1'b1;
            rep.items  = hist_items[idx];
            rep.ones   = hist_ones[idx];
            rep.zeroes = hist_items[idx] - hist_ones[idx];
        end
        rep.used = USE_W'(held_buckets);
        return rep;
    endfunction

    task automatic check_field(input string field, input logic [OUT_COUNT_W-1:0] want,
                               input logic [OUT_COUNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        bucket_report_t want;
        if (!rst_n)
        begin
            held_buckets = 1;
            hist_items[0] = '0;
            hist_ones[0]  = '0;
            expected_reports.delete();
            error_count = 0;
            checked_results = 0;
            pending_results <= 0;
        end
        else
        begin
            // Retire the result beat first: it always belongs to an older input beat
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result beat with no input beat waiting");
                    error_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("items_in_bucket", want.items, items_in_bucket);
                    check_field("ones_in_bucket", want.ones, ones_in_bucket);
                    check_field("zeroes_in_bucket", want.zeroes, zeroes_in_bucket);
                    check_field("buckets_in_use", OUT_COUNT_W'(want.used),
                                OUT_COUNT_W'(buckets_in_use));
                    check_field("index_valid", OUT_COUNT_W'(want.valid),
                                OUT_COUNT_W'(index_valid));
                    check_field("add_refused", OUT_COUNT_W'(want.refused),
                                OUT_COUNT_W'(add_refused));
                    checked_results++;
                end
            end
            if (in_valid && !in_stall)
                expected_reports.push_back(predict_report(command, bit_value, bucket_index));
            pending_results <= expected_reports.size();
        end
    end

endmodule

[tb/sv/bit_history_bucket_merger_unit_tb.sv]
// ----------------------------------------------------------------------------
// bit_history_bucket_merger_unit_tb
// Drives add and read beats into the bucket merger under three idling mixes
// and reports the verdict of the history checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_history_bucket_merger_unit_tb;

    import bhbm_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_BEATS  = 210;
    localparam int DRAIN_CYCLES  = DEF_MAX_BUCKETS + 16;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   command;
    logic                   bit_value;
    logic [IDX_W-1:0]       bucket_index;
    logic                   out_valid;
    logic                   out_stall;
    logic [OUT_COUNT_W-1:0] items_in_bucket;
    logic [OUT_COUNT_W-1:0] ones_in_bucket;
    logic [OUT_COUNT_W-1:0] zeroes_in_bucket;
    logic [USE_W-1:0]       buckets_in_use;
    logic                   index_valid;
    logic                   add_refused;

    int error_count;
    int pending_results;
    int checked_results;

    int send_idle_pct;
    int recv_idle_pct;
    int add_beats;
    int read_beats;
    int idle_cycles;

    bit_history_bucket_merger_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .bit_value        (bit_value),
        .bucket_index     (bucket_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .items_in_bucket  (items_in_bucket),
        .ones_in_bucket   (ones_in_bucket),
        .zeroes_in_bucket (zeroes_in_bucket),
        .buckets_in_use   (buckets_in_use),
        .index_valid      (index_valid),
        .add_refused      (add_refused)
    );

    bhbm_history_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .bit_value        (bit_value),
        .bucket_index     (bucket_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .items_in_bucket  (items_in_bucket),
        .ones_in_bucket   (ones_in_bucket),
        .zeroes_in_bucket (zeroes_in_bucket),
        .buckets_in_use   (buckets_in_use),
        .index_valid      (index_valid),
        .add_refused      (add_refused),
        .error_count      (error_count),
        .pending_results  (pending_results),
        .checked_results  (checked_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure at the current phase rate
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Abort when neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat moved in %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one beat and hold it until accepted
    task automatic send_beat(input logic cmd, input logic bitv, input logic [IDX_W-1:0] idx);
        in_valid     <= 1'b1;
        command      <= cmd;
        bit_value    <= bitv;
        bucket_index <= idx;
        do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
        if (cmd == CMD_ADD)
            add_beats++;
        else
            read_beats++;
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct);
        int n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            sender_gap();
            if ($urandom_range(0, 99) < 55)
                send_beat(CMD_ADD, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 63)));
            else if ($urandom_range(0, 9) == 0)
                send_beat(CMD_READ, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 63)));
            else
                send_beat(CMD_READ, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 17)));
            if ($urandom_range(0, 63) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin : stimulus
        int k;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_ADD;
        bit_value    <= 1'b0;
        bucket_index <= '0;
        add_beats    = 0;
        read_beats   = 0;
        send_idle_pct = 38;
        recv_idle_pct = 69;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: the empty bucket, reads past the end, ignored fields, early merges
        send_beat(CMD_READ, 1'b0, '0);
        send_beat(CMD_READ, 1'b0, IDX_W'(1));
        send_beat(CMD_READ, 1'b1, '1);
        send_beat(CMD_ADD, 1'b1, '1);
        send_beat(CMD_READ, 1'b1, '0);
        send_beat(CMD_ADD, 1'b0, '0);
        send_beat(CMD_ADD, 1'b1, IDX_W'(42));
        send_beat(CMD_ADD, 1'b1, '0);
        send_beat(CMD_ADD, 1'b0, IDX_W'(21));
        send_beat(CMD_ADD, 1'b1, '1);
        send_beat(CMD_ADD, 1'b1, '0);
        send_beat(CMD_ADD, 1'b1, '0);
        for (k = 0; k < 6; k++)
        begin
            sender_gap();
            send_beat(CMD_READ, k[0], IDX_W'(k));
        end
        send_beat(CMD_READ, 1'b0, '1);
        drain_results();

        random_phase(38, 69);
        random_phase(69, 38);
        random_phase(0, 0);

        // Let any late beat surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d adds and %0d reads, %0d results checked, under three idling mixes.",
                 add_beats, read_beats, checked_results);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
